// File: rtl/lamb_pkg.sv
// shared types and constants of the label adjacency matrix builder
`default_nettype none

package lamb_pkg;

  localparam int LABEL_W     = 6;
  localparam int DEPTH_W     = 16;
  localparam int ROW_W       = 64;
  localparam int CMD_W       = 2;
  localparam int WIDTH_CFG_W = 11;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 16;

  localparam int MAX_LABELS_DEF = 64;
  localparam int MAX_WIDTH_DEF  = 1024;

  // command codes
  localparam logic [CMD_W-1:0] CMD_PIXEL = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEPTH_THR   = 1'd1;

  localparam logic [WIDTH_CFG_W-1:0] IMAGE_WIDTH_RST = 11'd640;
  localparam logic [DEPTH_W-1:0]     DEPTH_THR_RST   = 16'd10;

  typedef struct packed {
    logic               vld;
    logic [LABEL_W-1:0] label;
    logic [DEPTH_W-1:0] depth;
  } pix_t;

  typedef struct packed {
    logic clr;
    logic set_en;
    pix_t self;
    pix_t up;
    pix_t left;
    pix_t up_left;
    logic up_en;
    logic left_en;
    logic up_left_en;
  } adj_upd_t;

endpackage

`default_nettype wire

// File: rtl/lamb_if.sv
// channel interfaces of the label adjacency matrix builder
`default_nettype none

interface lamb_in_if;
  logic                            valid;
  logic                            ready;
  logic [lamb_pkg::CMD_W-1:0]      command;
  logic                            label_valid;
  logic [lamb_pkg::LABEL_W-1:0]    pixel_label;
  logic [lamb_pkg::DEPTH_W-1:0]    depth_mm;
  logic [lamb_pkg::LABEL_W-1:0]    row_select;

  modport source (output valid, command, label_valid, pixel_label, depth_mm, row_select,
                  input ready);
  modport sink (input valid, command, label_valid, pixel_label, depth_mm, row_select,
                output ready);
endinterface

interface lamb_out_if;
  logic                         valid;
  logic                         ready;
  logic [lamb_pkg::ROW_W-1:0]   adjacent_2d_row;
  logic [lamb_pkg::ROW_W-1:0]   adjacent_3d_row;

  modport source (output valid, adjacent_2d_row, adjacent_3d_row, input ready);
  modport sink (input valid, adjacent_2d_row, adjacent_3d_row, output ready);
endinterface

interface lamb_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [lamb_pkg::CFG_IDX_W-1:0]    index;
  logic [lamb_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: rtl/lamb_line_buf.sv
// previous raster line store: label, valid bit and depth per column
`default_nettype none

module lamb_line_buf #(
  parameter int DEPTH = lamb_pkg::MAX_WIDTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  lamb_pkg::pix_t           wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output lamb_pkg::pix_t           rd_data_o
);

  lamb_pkg::pix_t mem_q [DEPTH];
  lamb_pkg::pix_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

// File: rtl/lamb_adj_matrix.sv
// 2d and 3d adjacency bit matrices with neighbor compare and row read
`default_nettype none

module lamb_adj_matrix #(
  parameter int MAX_LABELS = lamb_pkg::MAX_LABELS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  lamb_pkg::adj_upd_t             upd_i,
  input  logic [lamb_pkg::DEPTH_W-1:0]   thr_i,
  input  logic [lamb_pkg::LABEL_W-1:0]   rd_sel_i,
  output logic [lamb_pkg::ROW_W-1:0]     row_2d_o,
  output logic [lamb_pkg::ROW_W-1:0]     row_3d_o
);

  localparam int IDX_W = $clog2(MAX_LABELS);

  logic [MAX_LABELS-1:0] m2d_q [MAX_LABELS];
  logic [MAX_LABELS-1:0] m3d_q [MAX_LABELS];
  logic [MAX_LABELS-1:0] set_2d [MAX_LABELS];
  logic [MAX_LABELS-1:0] set_3d [MAX_LABELS];

  lamb_pkg::pix_t        nb [3];
  logic [2:0]            nb_en;
  logic [2:0]            hit_2d;
  logic [2:0]            hit_3d;
  logic [MAX_LABELS-1:0] oh_self;
  logic [MAX_LABELS-1:0] oh_nb [3];

  function automatic logic [lamb_pkg::DEPTH_W-1:0] abs_diff(
    input logic [lamb_pkg::DEPTH_W-1:0] a,
    input logic [lamb_pkg::DEPTH_W-1:0] b
  );
    abs_diff = (a >= b) ? (a - b) : (b - a);
  endfunction

  // neighbor compares
  always_comb begin
    nb[0] = upd_i.up;
    nb[1] = upd_i.left;
    nb[2] = upd_i.up_left;
    nb_en = {upd_i.up_left_en, upd_i.left_en, upd_i.up_en};
    for (int k = 0; k < 3; k++) begin
      hit_2d[k] = nb_en[k] && nb[k].vld && (nb[k].label != upd_i.self.label);
      hit_3d[k] = hit_2d[k] && (abs_diff(upd_i.self.depth, nb[k].depth) < thr_i);
    end
    for (int i = 0; i < MAX_LABELS; i++) begin
      oh_self[i] = (upd_i.self.label == lamb_pkg::LABEL_W'(i));
      for (int k = 0; k < 3; k++) begin
        oh_nb[k][i] = (nb[k].label == lamb_pkg::LABEL_W'(i));
      end
    end
  end

  // symmetric set masks, one per row
  always_comb begin
    for (int r = 0; r < MAX_LABELS; r++) begin
      set_2d[r] = '0;
      set_3d[r] = '0;
      for (int j = 0; j < MAX_LABELS; j++) begin
        for (int k = 0; k < 3; k++) begin
          set_2d[r][j] = set_2d[r][j] | (hit_2d[k] &
                         ((oh_self[r] & oh_nb[k][j]) | (oh_nb[k][r] & oh_self[j])));
          set_3d[r][j] = set_3d[r][j] | (hit_3d[k] &
                         ((oh_self[r] & oh_nb[k][j]) | (oh_nb[k][r] & oh_self[j])));
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < MAX_LABELS; r++) begin
        m2d_q[r] <= '0;
        m3d_q[r] <= '0;
      end
    end else if (upd_i.clr) begin
      for (int r = 0; r < MAX_LABELS; r++) begin
        m2d_q[r] <= '0;
        m3d_q[r] <= '0;
      end
    end else if (upd_i.set_en) begin
      for (int r = 0; r < MAX_LABELS; r++) begin
        m2d_q[r] <= m2d_q[r] | set_2d[r];
        m3d_q[r] <= m3d_q[r] | set_3d[r];
      end
    end
  end

  // row read, labels past the matrix read as zero
  always_comb begin
    if ({1'b0, rd_sel_i} < (lamb_pkg::LABEL_W + 1)'(MAX_LABELS)) begin
      row_2d_o = lamb_pkg::ROW_W'(m2d_q[rd_sel_i[IDX_W-1:0]]);
      row_3d_o = lamb_pkg::ROW_W'(m3d_q[rd_sel_i[IDX_W-1:0]]);
    end else begin
      row_2d_o = '0;
      row_3d_o = '0;
    end
  end

endmodule

`default_nettype wire

// File: rtl/label_adjacency_matrix_builder.sv
// top level: raster label stream to region adjacency matrices
//
// pix_i carries one command per transfer: a pixel in raster order, a row read
// or a frame clear. pixels update the 2d and 3d adjacency matrices from the
// up, left and up-left neighbors; a row read returns one row of each matrix
// on row_o; clear empties both matrices and restarts the raster position.
// cfg_i writes image_width (index 0) and depth_threshold_mm (index 1); it is
// always ready; the user must see it is written only while the block is idle.
// throughput: one command per cycle, except while a read waits at the compare
// stage. the line buffer is a single memory read once per pixel at the column
// counter and written in the next cycle from the compare stage.
// a row read passes the compare stage and is then held in the output register;
// pixels and clears give no transfer on row_o.
// when row_o stalls, one read result waits in the output register and the
// next command is still taken; only a second read stops at the compare
// stage and holds pix_i.ready low until the result leaves.
// reset clears the matrices, the neighbor registers and the raster position
// at once; the line buffer needs no clearing, first-line pixels ignore its data.
`default_nettype none

module label_adjacency_matrix_builder #(
  parameter int MAX_LABELS = lamb_pkg::MAX_LABELS_DEF,
  parameter int MAX_WIDTH  = lamb_pkg::MAX_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  lamb_in_if.sink     pix_i,
  lamb_out_if.source  row_o,
  lamb_cfg_if.sink    cfg_i
);

  localparam int CNT_W  = $clog2(MAX_WIDTH);
  localparam int BASE_W = (CNT_W + 1 > lamb_pkg::WIDTH_CFG_W) ? CNT_W + 1
                                                               : lamb_pkg::WIDTH_CFG_W;
  localparam int EXT_W  = BASE_W + 1;

  // configuration
  logic [lamb_pkg::WIDTH_CFG_W-1:0] width_q;
  logic [lamb_pkg::DEPTH_W-1:0]     thr_q;

  // raster position, advanced at the input transfer
  logic [CNT_W-1:0] col_q, col_d;
  logic             first_q, first_d;
  logic [EXT_W-1:0] width_ext;
  logic [EXT_W-1:0] eff_width;
  logic [EXT_W-1:0] col_inc;
  logic             line_wrap;
  logic             in_xfer;
  lamb_pkg::pix_t   in_pix;

  // compare stage
  logic                          s1_valid_q;
  logic [lamb_pkg::CMD_W-1:0]    s1_cmd_q;
  lamb_pkg::pix_t                s1_self_q;
  logic [CNT_W-1:0]              s1_col_q;
  logic                          s1_col_nz_q;
  logic                          s1_first_q;
  logic [lamb_pkg::LABEL_W-1:0]  s1_sel_q;
  logic                          s1_fwd_q;
  lamb_pkg::pix_t                s1_fwd_pix_q;
  logic                          s1_is_pix;
  logic                          s1_is_clr;
  logic                          s1_is_rd;
  logic                          s1_done;

  lamb_pkg::pix_t     left_q;
  lamb_pkg::pix_t     up_left_q;
  lamb_pkg::pix_t     lb_rd_pix;
  lamb_pkg::pix_t     up_pix;
  lamb_pkg::adj_upd_t upd;

  // result register
  logic                        out_valid_q;
  logic [lamb_pkg::ROW_W-1:0]  out_2d_q;
  logic [lamb_pkg::ROW_W-1:0]  out_3d_q;
  logic [lamb_pkg::ROW_W-1:0]  row_2d;
  logic [lamb_pkg::ROW_W-1:0]  row_3d;

  // configuration port
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= lamb_pkg::IMAGE_WIDTH_RST;
      thr_q   <= lamb_pkg::DEPTH_THR_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        lamb_pkg::REG_IMAGE_WIDTH: begin
          width_q <= cfg_i.data[lamb_pkg::WIDTH_CFG_W-1:0];
        end
        lamb_pkg::REG_DEPTH_THR: begin
          thr_q <= cfg_i.data[lamb_pkg::DEPTH_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // handshake: the compare stage frees itself every cycle except for a
  // read whose result register is still occupied
  assign s1_is_pix = (s1_cmd_q == lamb_pkg::CMD_PIXEL);
  assign s1_is_clr = (s1_cmd_q == lamb_pkg::CMD_CLEAR);
  assign s1_is_rd  = (s1_cmd_q == lamb_pkg::CMD_READ);
  assign s1_done   = s1_valid_q && (!s1_is_rd || !out_valid_q || row_o.ready);
  assign pix_i.ready = !s1_valid_q || s1_done;
  assign in_xfer     = pix_i.valid && pix_i.ready;

  // effective line width: zero acts as one, clamp to the line buffer depth
  always_comb begin
    width_ext = EXT_W'(width_q);
    if (width_ext == '0) begin
      eff_width = EXT_W'(1);
    end else if (width_ext > EXT_W'(MAX_WIDTH)) begin
      eff_width = EXT_W'(MAX_WIDTH);
    end else begin
      eff_width = width_ext;
    end
    col_inc   = EXT_W'(col_q) + EXT_W'(1);
    line_wrap = (col_inc >= eff_width);
  end

  always_comb begin
    col_d   = col_q;
    first_d = first_q;
    if (in_xfer) begin
      case (pix_i.command)
        lamb_pkg::CMD_PIXEL: begin
          if (line_wrap) begin
            col_d   = '0;
            first_d = 1'b0;
          end else begin
            col_d = col_inc[CNT_W-1:0];
          end
        end
        lamb_pkg::CMD_CLEAR: begin
          col_d   = '0;
          first_d = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      first_q <= 1'b1;
    end else begin
      col_q   <= col_d;
      first_q <= first_d;
    end
  end

  // labels past the matrix count as unlabelled
  always_comb begin
    in_pix.vld   = pix_i.label_valid &&
                   ({1'b0, pix_i.pixel_label} < (lamb_pkg::LABEL_W + 1)'(MAX_LABELS));
    in_pix.label = pix_i.pixel_label;
    in_pix.depth = pix_i.depth_mm;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_q <= 1'b1;
    end else if (s1_done) begin
      s1_valid_q <= 1'b0;
    end
  end

  // stage payload; the up neighbor is forwarded from the stage when the
  // previous pixel writes the same column (one-pixel-wide lines)
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_cmd_q     <= pix_i.command;
      s1_self_q    <= in_pix;
      s1_col_q     <= col_q;
      s1_col_nz_q  <= (col_q != '0);
      s1_first_q   <= first_q;
      s1_sel_q     <= pix_i.row_select;
      s1_fwd_q     <= s1_valid_q && s1_is_pix && (s1_col_q == col_q);
      s1_fwd_pix_q <= s1_self_q;
    end
  end

  lamb_line_buf #(
    .DEPTH (MAX_WIDTH)
  ) u_line_buf (
    .clk_i     (clk_i),
    .wr_en_i   (s1_valid_q && s1_is_pix),
    .wr_addr_i (s1_col_q),
    .wr_data_i (s1_self_q),
    .rd_en_i   (in_xfer && (pix_i.command == lamb_pkg::CMD_PIXEL)),
    .rd_addr_i (col_q),
    .rd_data_o (lb_rd_pix)
  );

  always_comb begin
    if (s1_first_q) begin
      up_pix = '0;
    end else if (s1_fwd_q) begin
      up_pix = s1_fwd_pix_q;
    end else begin
      up_pix = lb_rd_pix;
    end
  end

  always_comb begin
    upd.clr        = s1_valid_q && s1_is_clr;
    upd.set_en     = s1_valid_q && s1_is_pix && s1_self_q.vld;
    upd.self       = s1_self_q;
    upd.up         = up_pix;
    upd.left       = left_q;
    upd.up_left    = up_left_q;
    upd.up_en      = !s1_first_q;
    upd.left_en    = s1_col_nz_q;
    upd.up_left_en = s1_col_nz_q && !s1_first_q;
  end

  // neighbor registers follow the stream in order
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q    <= '0;
      up_left_q <= '0;
    end else if (s1_valid_q && s1_is_clr) begin
      left_q    <= '0;
      up_left_q <= '0;
    end else if (s1_valid_q && s1_is_pix) begin
      left_q    <= s1_self_q;
      up_left_q <= up_pix;
    end
  end

  lamb_adj_matrix #(
    .MAX_LABELS (MAX_LABELS)
  ) u_adj_matrix (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .upd_i    (upd),
    .thr_i    (thr_q),
    .rd_sel_i (s1_sel_q),
    .row_2d_o (row_2d),
    .row_3d_o (row_3d)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_done && s1_is_rd) begin
      out_valid_q <= 1'b1;
    end else if (row_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_done && s1_is_rd) begin
      out_2d_q <= row_2d;
      out_3d_q <= row_3d;
    end
  end

  assign row_o.valid           = out_valid_q;
  assign row_o.adjacent_2d_row = out_2d_q;
  assign row_o.adjacent_3d_row = out_3d_q;

endmodule

`default_nettype wire
